### src/tlpt_pkg.sv
// Shared types, codes and control structs for the three-level page table.
package tlpt_pkg;

  localparam int ADDR_W  = 48;
  localparam int PAGES_W = 5;
  localparam int EXT_W   = 64;  // host address widened so any index field fits

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [PAGES_W-1:0] pages_t;
  typedef logic [1:0]         action_t;
  typedef logic [1:0]         status_t;

  // Request actions
  localparam action_t ACT_INSERT    = 2'd0;
  localparam action_t ACT_REMOVE    = 2'd1;
  localparam action_t ACT_TRANSLATE = 2'd2;

  // Response status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_MISS      = 2'd1;
  localparam status_t ST_CONFLICT  = 2'd2;
  localparam status_t ST_POOL_FULL = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic idle;       // request port open
    logic clear;      // clearing pass, one entry per cycle
    logic walk_dir;   // issue directory read
    logic walk_leaf;  // issue leaf read
    logic commit;     // apply updates and load the response register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic accept;      // request beat taken this cycle
    logic clear_done;  // last entry of the clearing pass
    logic out_busy;    // response register still held by the sink
  } dp_sts_t;

endpackage

### src/tlpt_req_if.sv
// Request channel: action, host address and device address.
interface tlpt_req_if;
  import tlpt_pkg::*;

  logic    valid;
  logic    ready;
  action_t action;
  addr_t   host_address;
  addr_t   device_address;

  modport source (output valid, action, host_address, device_address, input ready);
  modport sink   (input valid, action, host_address, device_address, output ready);
endinterface

### src/tlpt_rsp_if.sv
// Response channel: status, translated address and page count.
interface tlpt_rsp_if;
  import tlpt_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  addr_t   translated_address;
  pages_t  pages_in_use;

  modport source (output valid, status, translated_address, pages_in_use, input ready);
  modport sink   (input valid, status, translated_address, pages_in_use, output ready);
endinterface

### src/tlpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tlpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/tlpt_ctrl.sv
// Sequencer for the page table walk: clear pass, three reads, commit.
module tlpt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  tlpt_pkg::dp_sts_t sts,
  output tlpt_pkg::dp_cmd_t cmd
);
  import tlpt_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIR,
    S_LEAF,
    S_COMMIT
  } state_t;

  state_t state;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      case (state)
        S_CLEAR:  if (sts.clear_done) state <= S_IDLE;
        S_IDLE:   if (sts.accept) state <= S_DIR;
        S_DIR:    state <= S_LEAF;
        S_LEAF:   state <= S_COMMIT;
        S_COMMIT: if (!sts.out_busy) state <= S_IDLE;
        default:  state <= S_CLEAR;
      endcase
    end
  end

  // Commands decoded from state; commit waits for a free response register
  always_comb begin
    cmd           = '0;
    cmd.idle      = (state == S_IDLE);
    cmd.clear     = (state == S_CLEAR);
    cmd.walk_dir  = (state == S_DIR);
    cmd.walk_leaf = (state == S_LEAF);
    cmd.commit    = (state == S_COMMIT) && !sts.out_busy;
  end

endmodule

### src/tlpt_datapath.sv
// Page table storage, walk addressing, update decision and response register.
module tlpt_datapath #(
  parameter int PAGE_SHIFT = 12,
  parameter int TABLE_BITS = 6,
  parameter int DIR_BITS   = 6,
  parameter int ROOT_BITS  = 4,
  parameter int DIR_POOL   = 4,
  parameter int TABLE_POOL = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  tlpt_pkg::dp_cmd_t cmd,
  output tlpt_pkg::dp_sts_t sts,
  tlpt_req_if.sink          req,
  tlpt_rsp_if.source        rsp
);
  import tlpt_pkg::*;

  localparam int ROOT_DEPTH = 1 << ROOT_BITS;
  localparam int DIR_DEPTH  = DIR_POOL << DIR_BITS;
  localparam int LEAF_DEPTH = TABLE_POOL << TABLE_BITS;
  localparam int ROOT_AW    = $clog2(ROOT_DEPTH);
  localparam int DIR_AW     = $clog2(DIR_DEPTH);
  localparam int LEAF_AW    = $clog2(LEAF_DEPTH);
  localparam int DSLOT_W    = (DIR_POOL > 1) ? $clog2(DIR_POOL) : 1;
  localparam int TSLOT_W    = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
  localparam int DCNT_W     = $clog2(DIR_POOL + 1);
  localparam int TCNT_W     = $clog2(TABLE_POOL + 1);
  localparam int MAX_A      = (ROOT_DEPTH > DIR_DEPTH) ? ROOT_DEPTH : DIR_DEPTH;
  localparam int MAX_DEPTH  = (MAX_A > LEAF_DEPTH) ? MAX_A : LEAF_DEPTH;
  localparam int CLR_W      = $clog2(MAX_DEPTH);
  localparam int TI_LSB     = PAGE_SHIFT;
  localparam int DI_LSB     = PAGE_SHIFT + TABLE_BITS;
  localparam int RI_LSB     = DI_LSB + DIR_BITS;

  // Request capture
  action_t              act_q;
  addr_t                host_q;
  addr_t                dev_q;
  logic [EXT_W-1:0]     host_ext_q;
  logic [EXT_W-1:0]     host_ext_in;
  logic [TABLE_BITS-1:0] ti_q;
  logic [DIR_BITS-1:0]  di_q;
  logic [ROOT_BITS-1:0] ri_q;
  logic [ROOT_BITS-1:0] ri_in;
  logic                 accept;

  assign req.ready   = cmd.idle;
  assign accept      = req.valid && req.ready;
  assign host_ext_in = {{(EXT_W - ADDR_W){1'b0}}, req.host_address};
  assign ri_in       = host_ext_in[RI_LSB +: ROOT_BITS];
  assign host_ext_q  = {{(EXT_W - ADDR_W){1'b0}}, host_q};
  assign ti_q        = host_ext_q[TI_LSB +: TABLE_BITS];
  assign di_q        = host_ext_q[DI_LSB +: DIR_BITS];
  assign ri_q        = host_ext_q[RI_LSB +: ROOT_BITS];

  always_ff @(posedge clk) begin
    if (accept) begin
      act_q  <= req.action;
      host_q <= req.host_address;
      dev_q  <= req.device_address;
    end
  end

  // Clearing pass counter
  logic [CLR_W-1:0] clr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (cmd.clear) begin
      clr <= clr + 1'b1;
    end
  end

  // Pool allocation counters
  logic [DCNT_W-1:0] dused;
  logic [DCNT_W-1:0] dused_next;
  logic [TCNT_W-1:0] tused;
  logic [TCNT_W-1:0] tused_next;

  // Memory ports
  logic                   root_we, dir_we, leaf_we;
  logic [ROOT_AW-1:0]     root_waddr;
  logic [DIR_AW-1:0]      dir_waddr, dir_raddr;
  logic [LEAF_AW-1:0]     leaf_waddr, leaf_raddr;
  logic [DSLOT_W:0]       root_wdata, root_rdata;
  logic [TSLOT_W:0]       dir_wdata, dir_rdata;
  logic [ADDR_W:0]        leaf_wdata, leaf_rdata;

  tlpt_ram #(.WIDTH(DSLOT_W + 1), .DEPTH(ROOT_DEPTH)) u_root_ram (
    .clk   (clk),
    .we    (root_we),
    .waddr (root_waddr),
    .wdata (root_wdata),
    .re    (accept),
    .raddr (ri_in),
    .rdata (root_rdata)
  );

  tlpt_ram #(.WIDTH(TSLOT_W + 1), .DEPTH(DIR_DEPTH)) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .re    (cmd.walk_dir),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  tlpt_ram #(.WIDTH(ADDR_W + 1), .DEPTH(LEAF_DEPTH)) u_leaf_ram (
    .clk   (clk),
    .we    (leaf_we),
    .waddr (leaf_waddr),
    .wdata (leaf_wdata),
    .re    (cmd.walk_leaf),
    .raddr (leaf_raddr),
    .rdata (leaf_rdata)
  );

  // Entry fields; read data stays put until the next walk step
  logic               root_p, dir_p, leaf_p;
  logic [DSLOT_W-1:0] root_slot;
  logic [TSLOT_W-1:0] dir_slot;
  addr_t              leaf_tgt;

  assign root_p    = root_rdata[DSLOT_W];
  assign root_slot = root_rdata[DSLOT_W-1:0];
  assign dir_p     = dir_rdata[TSLOT_W];
  assign dir_slot  = dir_rdata[TSLOT_W-1:0];
  assign leaf_p    = leaf_rdata[ADDR_W];
  assign leaf_tgt  = leaf_rdata[ADDR_W-1:0];

  assign dir_raddr  = DIR_AW'({root_slot, di_q});
  assign leaf_raddr = LEAF_AW'({dir_slot, ti_q});

  // Update decision
  logic               need_dir, need_tab, pool_full, conflict, hit;
  logic [DSLOT_W-1:0] ds_new;
  logic [TSLOT_W-1:0] ts_new;
  logic               wr_root, wr_dir, wr_leaf, leaf_clear;
  status_t            status_next;
  addr_t              xlat_next;

  assign need_dir  = !root_p;
  assign need_tab  = need_dir || !dir_p;
  assign pool_full = (need_dir && (dused >= DCNT_W'(DIR_POOL))) ||
                     (need_tab && (tused >= TCNT_W'(TABLE_POOL)));
  assign conflict  = !need_tab && leaf_p && (leaf_tgt != dev_q);
  assign hit       = root_p && dir_p && leaf_p;
  assign ds_new    = need_dir ? DSLOT_W'(dused) : root_slot;
  assign ts_new    = need_tab ? TSLOT_W'(tused) : dir_slot;

  always_comb begin
    status_next = ST_MISS;
    xlat_next   = '0;
    wr_root     = 1'b0;
    wr_dir      = 1'b0;
    wr_leaf     = 1'b0;
    leaf_clear  = 1'b0;
    dused_next  = dused;
    tused_next  = tused;
    case (act_q)
      ACT_INSERT: begin
        if (pool_full) begin
          status_next = ST_POOL_FULL;
        end else if (conflict) begin
          status_next = ST_CONFLICT;
        end else begin
          status_next = ST_OK;
          wr_root     = need_dir;
          wr_dir      = need_tab;
          wr_leaf     = 1'b1;
          if (need_dir) dused_next = dused + 1'b1;
          if (need_tab) tused_next = tused + 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (hit) begin
          status_next = ST_OK;
          wr_leaf     = 1'b1;
          leaf_clear  = 1'b1;
        end
      end
      ACT_TRANSLATE: begin
        if (hit) begin
          status_next = ST_OK;
          xlat_next   = leaf_tgt + ADDR_W'(host_q[PAGE_SHIFT-1:0]);
        end
      end
      default: begin
        status_next = ST_MISS;
      end
    endcase
  end

  // Write ports: zeros during the clearing pass, updates at commit
  always_comb begin
    if (cmd.clear) begin
      root_we    = ({1'b0, clr} < (CLR_W + 1)'(ROOT_DEPTH));
      dir_we     = ({1'b0, clr} < (CLR_W + 1)'(DIR_DEPTH));
      leaf_we    = ({1'b0, clr} < (CLR_W + 1)'(LEAF_DEPTH));
      root_waddr = ROOT_AW'(clr);
      dir_waddr  = DIR_AW'(clr);
      leaf_waddr = LEAF_AW'(clr);
      root_wdata = '0;
      dir_wdata  = '0;
      leaf_wdata = '0;
    end else begin
      root_we    = cmd.commit && wr_root;
      dir_we     = cmd.commit && wr_dir;
      leaf_we    = cmd.commit && wr_leaf;
      root_waddr = ri_q;
      dir_waddr  = DIR_AW'({ds_new, di_q});
      leaf_waddr = LEAF_AW'({ts_new, ti_q});
      root_wdata = {1'b1, ds_new};
      dir_wdata  = {1'b1, ts_new};
      leaf_wdata = leaf_clear ? {1'b0, leaf_tgt} : {1'b1, dev_q};
    end
  end

  // Counters and response register
  logic rsp_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      dused     <= '0;
      tused     <= '0;
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      dused     <= dused_next;
      tused     <= tused_next;
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.status             <= status_next;
      rsp.translated_address <= xlat_next;
      rsp.pages_in_use       <= PAGES_W'(1) + PAGES_W'(dused_next) + PAGES_W'(tused_next);
    end
  end

  assign rsp.valid = rsp_valid;

  assign sts.accept     = accept;
  assign sts.clear_done = (clr == CLR_W'(MAX_DEPTH - 1));
  assign sts.out_busy   = rsp_valid && !rsp.ready;

`ifndef SYNTHESIS
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    (dused <= DCNT_W'(DIR_POOL)) && (tused <= TCNT_W'(TABLE_POOL)))
    else $error("allocation counter beyond its pool");

  a_count_only_at_commit: assert property (@(posedge clk) disable iff (rst)
    !cmd.commit |=> $stable(dused) && $stable(tused))
    else $error("allocation counter moved without a commit");

  a_commit_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!rsp_valid || rsp.ready))
    else $error("commit over a response beat not yet taken");

  a_xlat_zero_unless_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status != ST_OK)) |-> (rsp.translated_address == '0))
    else $error("nonzero translated address on a failed request");
`endif

endmodule

### src/three_level_page_table.sv
// Top level of the three-level page table: controller plus datapath.
//
//   channel  dir  beat contents
//   -------  ---  -----------------------------------------------
//   req      in   action, host_address, device_address
//   rsp      out  status, translated_address, pages_in_use
//
// Each request steps through the accept cycle, which issues the root read,
// then the directory read, the leaf read, and the update/response cycle.
// The three dependent reads on the registered-read table memories set this order.
// After rst a clearing pass writes zeros to every entry of the root, directory
// and leaf memories while req.ready is low.
// A new request is taken while a response beat waits; its commit waits until
// the previous response has been taken.
module three_level_page_table #(
  parameter int PAGE_SHIFT = 12,
  parameter int TABLE_BITS = 6,
  parameter int DIR_BITS   = 6,
  parameter int ROOT_BITS  = 4,
  parameter int DIR_POOL   = 4,
  parameter int TABLE_POOL = 16
) (
  input logic        clk,
  input logic        rst,
  tlpt_req_if.sink   req,
  tlpt_rsp_if.source rsp
);
  import tlpt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  tlpt_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  tlpt_datapath #(
    .PAGE_SHIFT (PAGE_SHIFT),
    .TABLE_BITS (TABLE_BITS),
    .DIR_BITS   (DIR_BITS),
    .ROOT_BITS  (ROOT_BITS),
    .DIR_POOL   (DIR_POOL),
    .TABLE_POOL (TABLE_POOL)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts),
    .req (req),
    .rsp (rsp)
  );

endmodule

### tb/sv/three_level_page_table_test.sv
// Self-checking testbench for the three-level page table: random traffic checked by a scoreboard.
import tlpt_pkg::*;

// Geometry shared by the scoreboard and the stimulus (block defaults)
localparam int PAGE_SHIFT = 12;
localparam int TABLE_BITS = 6;
localparam int DIR_BITS   = 6;
localparam int ROOT_BITS  = 4;
localparam int DIR_POOL   = 4;
localparam int TABLE_POOL = 16;

localparam int TABLE_SIZE = 1 << TABLE_BITS;
localparam int DIR_SIZE   = 1 << DIR_BITS;
localparam int ROOT_SIZE  = 1 << ROOT_BITS;
localparam int TABLE_LSB  = PAGE_SHIFT;
localparam int DIR_LSB    = TABLE_LSB + TABLE_BITS;
localparam int ROOT_LSB   = DIR_LSB + DIR_BITS;
localparam int INDEX_TOP  = ROOT_LSB + ROOT_BITS;

// Action value the block does not define; answered as a miss
localparam action_t ACT_UNDEFINED = 2'd3;

typedef struct packed {
  status_t status;
  addr_t   translated;
  pages_t  pages;
} page_result_t;

// Mirrors the page table and queues the response each request should produce
class page_table_scoreboard;
  bit          root_valid [ROOT_SIZE];
  int unsigned root_slot  [ROOT_SIZE];
  bit          dir_valid  [DIR_POOL * DIR_SIZE];
  int unsigned dir_slot   [DIR_POOL * DIR_SIZE];
  bit          leaf_valid [TABLE_POOL * TABLE_SIZE];
  addr_t       leaf_addr  [TABLE_POOL * TABLE_SIZE];
  int unsigned dirs_used;
  int unsigned tables_used;
  page_result_t pending_responses[$];
  int unsigned failures;

  function new();
    foreach (root_valid[i]) root_valid[i] = 1'b0;
    foreach (dir_valid[i]) dir_valid[i] = 1'b0;
    foreach (leaf_valid[i]) leaf_valid[i] = 1'b0;
    dirs_used = 0;
    tables_used = 0;
    failures = 0;
  endfunction

  function int unsigned pending();
    return pending_responses.size();
  endfunction

  // Update the mirror for an accepted request beat and queue its response
  function void apply_request(action_t act, addr_t host, addr_t dev);
    int unsigned ti, di, ri, ds, de, le;
    addr_t offs;
    bit need_dir, need_tab, conflict;
    page_result_t r;
    ti = 32'(host[TABLE_LSB +: TABLE_BITS]);
    di = 32'(host[DIR_LSB +: DIR_BITS]);
    ri = 32'(host[ROOT_LSB +: ROOT_BITS]);
    offs = '0;
    offs[PAGE_SHIFT-1:0] = host[PAGE_SHIFT-1:0];
    r.status = ST_MISS;
    r.translated = '0;
    de = 0;
    case (act)
      ACT_INSERT: begin
        need_dir = !root_valid[ri];
        need_tab = need_dir;
        if (!need_dir) begin
          ds = root_slot[ri];
          de = ds * DIR_SIZE + di;
          need_tab = !dir_valid[de];
        end
        // both pools checked before anything is allocated
        if ((need_dir && dirs_used >= DIR_POOL) ||
            (need_tab && tables_used >= TABLE_POOL)) begin
          r.status = ST_POOL_FULL;
        end else begin
          conflict = 1'b0;
          if (!need_tab) begin
            le = dir_slot[de] * TABLE_SIZE + ti;
            conflict = leaf_valid[le] && (leaf_addr[le] != dev);
          end
          if (conflict) begin
            r.status = ST_CONFLICT;
          end else begin
            if (need_dir) begin
              ds = dirs_used;
              dirs_used++;
              root_valid[ri] = 1'b1;
              root_slot[ri] = ds;
              de = ds * DIR_SIZE + di;
            end
            if (need_tab) begin
              dir_slot[de] = tables_used;
              tables_used++;
              dir_valid[de] = 1'b1;
            end
            le = dir_slot[de] * TABLE_SIZE + ti;
            leaf_valid[le] = 1'b1;
            leaf_addr[le] = dev;
            r.status = ST_OK;
          end
        end
      end
      ACT_REMOVE, ACT_TRANSLATE: begin
        if (root_valid[ri]) begin
          de = root_slot[ri] * DIR_SIZE + di;
          if (dir_valid[de]) begin
            le = dir_slot[de] * TABLE_SIZE + ti;
            if (leaf_valid[le]) begin
              r.status = ST_OK;
              if (act == ACT_REMOVE) leaf_valid[le] = 1'b0;
              else r.translated = leaf_addr[le] + offs;
            end
          end
        end
      end
      default: ;
    endcase
    r.pages = pages_t'(1 + dirs_used + tables_used);
    pending_responses.push_back(r);
  endfunction

  // Compare one response beat with the oldest queued response
  function void check_response(status_t st, addr_t xa, pages_t pg);
    page_result_t want;
    if (pending_responses.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected response beat: status %0d addr %h pages %0d", st, xa, pg);
      return;
    end
    want = pending_responses.pop_front();
    if (st !== want.status || xa !== want.translated || pg !== want.pages) begin
      failures++;
      if (failures <= 10)
        $display("response mismatch: expected status %0d addr %h pages %0d, got %0d %h %0d",
                 want.status, want.translated, want.pages, st, xa, pg);
    end
  endfunction
endclass

module three_level_page_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 620;
  localparam int TAIL_ITEMS   = 100;
  localparam int STALL_LIMIT  = 4000;  // covers the clearing pass after reset

  logic clk = 1'b0;
  logic rst;

  tlpt_req_if req_ch();
  tlpt_rsp_if rsp_ch();

  three_level_page_table #(
    .PAGE_SHIFT(PAGE_SHIFT),
    .TABLE_BITS(TABLE_BITS),
    .DIR_BITS(DIR_BITS),
    .ROOT_BITS(ROOT_BITS),
    .DIR_POOL(DIR_POOL),
    .TABLE_POOL(TABLE_POOL)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  page_table_scoreboard ledger;
  addr_t       seen_hosts[$];
  addr_t       seen_devs[$];
  bit          steady_tail = 1'b0;
  int unsigned stall_left = 0;
  int unsigned dead_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Response side: check each beat, stall ready in random bursts
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      ledger.check_response(rsp_ch.status, rsp_ch.translated_address, rsp_ch.pages_in_use);
    if (stall_left != 0) stall_left--;
    else if (!steady_tail && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 17);
    rsp_ch.ready <= (stall_left == 0);
  end

  // Watchdog: too long without any beat on either channel
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) dead_cycles = 0;
    else dead_cycles++;
    if (dead_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic addr_t host_at(int unsigned r, int unsigned d, int unsigned t,
                                    int unsigned off);
    addr_t h;
    h = '0;
    h[ROOT_LSB +: ROOT_BITS] = ROOT_BITS'(r);
    h[DIR_LSB +: DIR_BITS] = DIR_BITS'(d);
    h[TABLE_LSB +: TABLE_BITS] = TABLE_BITS'(t);
    h[PAGE_SHIFT-1:0] = PAGE_SHIFT'(off);
    return h;
  endfunction

  // Random host address, mostly steered to roots and directories that exist
  function automatic addr_t make_host();
    addr_t h;
    int unsigned r, d;
    h = addr_t'({$urandom(), $urandom()});
    if ($urandom_range(0, 4) != 0) begin
      case ($urandom_range(0, 3))
        0: r = 0;
        1: r = 1;
        2: r = 2;
        default: r = ROOT_SIZE - 1;
      endcase
      h[ROOT_LSB +: ROOT_BITS] = ROOT_BITS'(r);
    end
    if ($urandom_range(0, 3) != 0) begin
      d = $urandom_range(0, 13);
      if (d == 13) d = DIR_SIZE - 1;
      h[DIR_LSB +: DIR_BITS] = DIR_BITS'(d);
    end
    return h;
  endfunction

  // Earlier inserted page with new offset and aliased upper bits
  function automatic addr_t alias_of(int unsigned idx);
    addr_t h;
    h = seen_hosts[idx];
    h[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom_range(0, (1 << PAGE_SHIFT) - 1));
    h[ADDR_W-1:INDEX_TOP] =
      (ADDR_W - INDEX_TOP)'($urandom_range(0, (1 << (ADDR_W - INDEX_TOP)) - 1));
    return h;
  endfunction

  // Present one request beat, optionally after an idle burst
  task automatic issue_request(action_t act, addr_t host, addr_t dev);
    int unsigned gap;
    gap = 0;
    if (!steady_tail && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 17);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.action <= act;
    req_ch.host_address <= host;
    req_ch.device_address <= dev;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    ledger.apply_request(act, host, dev);
    if (act == ACT_INSERT) begin
      seen_hosts.push_back(host);
      seen_devs.push_back(dev);
    end
  endtask

  initial begin
    int unsigned sel, pick;
    action_t act;
    addr_t host, dev;
    ledger = new();
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_INSERT;
    req_ch.host_address = '0;
    req_ch.device_address = '0;
    rsp_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: misses on an empty table, unknown action
    issue_request(ACT_TRANSLATE, '0, '0);
    issue_request(ACT_REMOVE, '0, '1);
    issue_request(ACT_UNDEFINED, '1, '1);
    // lowest and highest pages, offset carry past the top of the address
    issue_request(ACT_INSERT, '0, '0);
    issue_request(ACT_TRANSLATE, host_at(0, 0, 0, (1 << PAGE_SHIFT) - 1), '0);
    issue_request(ACT_INSERT, '1, '1);
    issue_request(ACT_TRANSLATE, '1, '0);
    // same target again is fine, a different one conflicts
    issue_request(ACT_INSERT, '1, '1);
    issue_request(ACT_INSERT, '1, '0);
    // upper bits alias onto page zero
    issue_request(ACT_TRANSLATE, 48'hFFFF_F000_0ABC, '0);
    // remove, then leaf and directory misses
    issue_request(ACT_REMOVE, '0, '0);
    issue_request(ACT_TRANSLATE, '0, '0);
    issue_request(ACT_TRANSLATE, host_at(0, 1, 0, 0), '0);
    // fill the directory pool, then one more root
    issue_request(ACT_INSERT, host_at(1, 0, 5, 0), addr_t'({$urandom(), $urandom()}));
    issue_request(ACT_INSERT, host_at(2, 0, 9, 0), addr_t'({$urandom(), $urandom()}));
    issue_request(ACT_INSERT, host_at(3, 0, 0, 0), addr_t'({$urandom(), $urandom()}));
    // fill the table pool, then one more directory entry
    for (int k = 1; k <= 13; k++)
      issue_request(ACT_INSERT, host_at(1, k, k, 0), addr_t'({$urandom(), $urandom()}));

    // Random traffic over the populated table
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - TAIL_ITEMS) steady_tail = 1'b1;
      sel = $urandom_range(0, 99);
      dev = addr_t'({$urandom(), $urandom()});
      pick = $urandom_range(0, seen_hosts.size() - 1);
      if (sel < 40) begin
        act = ACT_INSERT;
        if ($urandom_range(0, 9) < 3) begin
          host = alias_of(pick);
          if ($urandom_range(0, 1) == 1) dev = seen_devs[pick];
        end else begin
          host = make_host();
        end
      end else if (sel < 55) begin
        act = ACT_REMOVE;
        host = ($urandom_range(0, 9) < 7) ? alias_of(pick) : make_host();
      end else if (sel < 95) begin
        act = ACT_TRANSLATE;
        host = ($urandom_range(0, 3) != 0) ? alias_of(pick) : make_host();
      end else begin
        act = ACT_UNDEFINED;
        host = make_host();
      end
      issue_request(act, host, dev);
    end
    req_ch.valid <= 1'b0;

    // Drain outstanding responses, then settle
    while (ledger.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (ledger.failures == 0 && ledger.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
src/tlpt_pkg.sv
src/tlpt_req_if.sv
src/tlpt_rsp_if.sv
src/tlpt_ram.sv
src/tlpt_ctrl.sv
src/tlpt_datapath.sv
src/three_level_page_table.sv
tb/sv/three_level_page_table_test.sv
